FILE: design/are_pkg.sv
// Package for the adaptive range encoder: payload types, commands, states, constants.
// Depends on nothing; used by every module in design/.
package are_pkg;

    localparam int MAX_SYMBOLS_DEF   = 256;
    localparam int RESCALE_LIMIT_DEF = 65536;
    localparam logic [63:0] BOTTOM_BOUND_DEF = 64'd281474976710656;
    localparam logic [63:0] TOP_BOUND        = 64'd72057594037927936;
    localparam int FREQ_W  = 25;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        CMD_ENCODE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_TOTAL,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_W,
        ST_SHIFT,
        ST_EMIT,
        ST_BUMP,
        ST_HALVE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;

endpackage

FILE: design/adaptive_range_encoder.sv
// Top level of the adaptive order-0 range encoder.
// Depends on are_pkg, are_div, are_freq_mem.
//
// Usage:
//   in_valid/in_stall/in_data carry {cmd, symbol}; in_stall is high whenever
//   the sequencer is not idle, so one item is worked on at a time.
//   out_valid/out_stall/out_data carry {out_byte, last}: one transfer per coded
//   byte, last set on the final byte of an item.
//   cfg_we/cfg_wdata write symbol_count and restart the frequency table with a
//   sweep over all MAX_SYMBOLS+1 entries (entry i = i); write only while idle.
// Sequence:
//   Encode: table reads, the bit-serial divider, the two shift-add multiplies,
//   the bytes out, then an increment of each table entry above the symbol; a
//   rescale then halves the table. Flush: eight bytes out. Reset command: a
//   full table sweep.
// Reset: rst_n clears the coder and starts the table sweep; no item is
//   taken until it ends.
// Stall: each byte holds in out_data until taken; the sequencer waits.
module adaptive_range_encoder #(
    parameter int          MAX_SYMBOLS   = are_pkg::MAX_SYMBOLS_DEF,
    parameter int          RESCALE_LIMIT = are_pkg::RESCALE_LIMIT_DEF,
    parameter logic [63:0] BOTTOM_BOUND  = are_pkg::BOTTOM_BOUND_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  are_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output are_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic [are_pkg::COUNT_W-1:0] cfg_wdata
);
    import are_pkg::*;

    localparam int AW = $clog2(MAX_SYMBOLS + 1);
    // index also counts multiply steps and holds a symbol plus one
    localparam int IW = (AW > 8) ? AW : 8;
    localparam logic [FREQ_W-1:0] LIMIT = FREQ_W'(RESCALE_LIMIT);

    state_t            state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [63:0]       low_reg, low_next, range_reg, range_next;
    logic [63:0]       acc_reg, acc_next;
    logic [FREQ_W-1:0] mplier_reg, mplier_next;
    logic [FREQ_W-1:0] lo_reg, lo_next, hi_reg, hi_next, prev_reg, prev_next;
    logic [FREQ_W-1:0] total_reg, total_next;
    logic [IW:0]       idx_reg, idx_next;
    logic [7:0]        sym_reg, sym_next;
    logic [3:0]        nout_reg, nout_next;
    logic              phase_reg, phase_next;
    logic              clear_pend_reg, clear_pend_next;
    logic              ov_reg, ov_next;
    out_item_t         od_reg, od_next;
    logic [7:0]        byte_hold_reg, byte_hold_next;

    logic [IW:0]       n_eff;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [FREQ_W-1:0] wdata, rdata, halved;
    logic              div_start;
    div_ctl_t          div_ctl;
    logic [63:0]       quotient, sum, hi_sum;
    logic              settled, below_bottom;

    are_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(range_reg),
        .divisor(total_reg), .ctl(div_ctl), .quotient(quotient)
    );

    are_freq_mem #(.DEPTH(MAX_SYMBOLS + 1)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // effective count clamps 0 to 1 and above MAX_SYMBOLS to MAX_SYMBOLS
    always_comb
    begin
        if (count_reg == '0)
            n_eff = (IW+1)'(1);
        else if (32'(count_reg) > MAX_SYMBOLS)
            n_eff = (IW+1)'(MAX_SYMBOLS);
        else
            n_eff = (IW+1)'(count_reg);
    end

    assign hi_sum       = low_reg + range_reg;
    assign settled      = (low_reg ^ hi_sum) < TOP_BOUND;
    assign below_bottom = range_reg < BOTTOM_BOUND;
    assign sum          = acc_reg + (mplier_reg[FREQ_W-1] ? quotient : 64'd0);
    assign halved       = {1'b0, rdata[FREQ_W-1:1]};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        acc_next        = acc_reg;
        mplier_next     = mplier_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        prev_next       = prev_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        sym_next        = sym_reg;
        nout_next       = nout_reg;
        phase_next      = phase_reg;
        clear_pend_next = clear_pend_reg;
        ov_next         = ov_reg;
        od_next         = od_reg;
        byte_hold_next  = byte_hold_reg;
        we              = 1'b0;
        waddr           = idx_reg[AW-1:0];
        wdata           = FREQ_W'(idx_reg);
        raddr           = idx_reg[AW-1:0];
        div_start       = 1'b0;
        in_stall        = 1'b1;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        if (cfg_we)
        begin
            count_next      = cfg_wdata;
            clear_pend_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = clear_pend_reg || cfg_we;
                if (clear_pend_reg)
                begin
                    clear_pend_next = cfg_we;
                    idx_next        = '0;
                    state_next      = ST_CLEAR;
                end
                else if (in_valid && !cfg_we)
                begin
                    sym_next = in_data.symbol;
                    unique case (cmd_t'(in_data.cmd))
                        CMD_ENCODE:
                        begin
                            if ((IW+1)'(in_data.symbol) < n_eff)
                            begin
                                idx_next   = n_eff;
                                state_next = ST_RD_TOTAL;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            nout_next  = '0;
                            phase_next = 1'b0;
                            state_next = ST_FLUSH;
                        end
                        CMD_RESET:
                        begin
                            low_next   = '0;
                            range_next = '1;
                            idx_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(MAX_SYMBOLS))
                    state_next = ST_IDLE;
            end
            ST_RD_TOTAL:
            begin
                // read issued; next cycle data valid
                idx_next   = (IW+1)'(sym_reg);
                phase_next = 1'b0;
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                raddr = idx_reg[AW-1:0];
                if (!phase_reg)
                begin
                    total_next = (rdata == '0) ? FREQ_W'(1) : rdata;
                    phase_next = 1'b1;
                end
                else
                begin
                    lo_next    = rdata;
                    idx_next   = idx_reg + 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_RD_HI;
                end
            end
            ST_RD_HI:
            begin
                if (!phase_reg)
                    phase_next = 1'b1;
                else
                begin
                    hi_next    = rdata;
                    div_start  = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_ctl.busy && phase_reg)
                begin
                    acc_next    = '0;
                    mplier_next = lo_reg;
                    idx_next    = '0;
                    state_next  = ST_MUL_LO;
                end
                phase_next = 1'b1;
            end
            ST_MUL_LO:
            begin
                // shift-add: acc = acc*2 + bit*q, msb first
                acc_next    = {sum[62:0], 1'b0};
                mplier_next = {mplier_reg[FREQ_W-2:0], 1'b0};
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(FREQ_W - 1))
                begin
                    low_next    = low_reg + sum;
                    acc_next    = '0;
                    mplier_next = hi_reg - lo_reg;
                    idx_next    = '0;
                    state_next  = ST_MUL_W;
                end
            end
            ST_MUL_W:
            begin
                acc_next    = {sum[62:0], 1'b0};
                mplier_next = {mplier_reg[FREQ_W-2:0], 1'b0};
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(FREQ_W - 1))
                begin
                    range_next = sum;
                    nout_next  = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if ((settled || below_bottom) && nout_reg != 4'd8)
                begin
                    if (below_bottom && !settled)
                        range_next = (64'd0 - low_reg) & (BOTTOM_BOUND - 64'd1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = (IW+1)'(sym_reg) + 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_BUMP;
                end
            end
            ST_EMIT:
            begin
                // held byte goes out once another one follows it
                if (!ov_reg || !out_stall)
                begin
                    if (nout_reg != '0)
                    begin
                        ov_next          = 1'b1;
                        od_next.out_byte = byte_hold_reg;
                        od_next.last     = 1'b0;
                    end
                    byte_hold_next = low_reg[63:56];
                    low_next       = {low_reg[55:0], 8'd0};
                    range_next     = {range_reg[55:0], 8'd0};
                    nout_next      = nout_reg + 1'b1;
                    state_next     = ST_SHIFT;
                end
            end
            ST_BUMP:
            begin
                // held byte is the final one of this item
                if (nout_reg != '0)
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_next          = 1'b1;
                        od_next.out_byte = byte_hold_reg;
                        od_next.last     = 1'b1;
                        nout_next        = '0;
                    end
                end
                else if (idx_reg > n_eff)
                begin
                    if (!phase_reg)
                        phase_next = 1'b1;
                    else if (total_reg + FREQ_W'(1) >= LIMIT)
                    begin
                        idx_next   = (IW+1)'(1);
                        prev_next  = '0;
                        phase_next = 1'b0;
                        state_next = ST_HALVE;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else if (!phase_reg)
                    phase_next = 1'b1;
                else
                begin
                    we         = 1'b1;
                    wdata      = rdata + FREQ_W'(1);
                    idx_next   = idx_reg + 1'b1;
                    phase_next = 1'b0;
                end
            end
            ST_HALVE:
            begin
                if (idx_reg > n_eff)
                    state_next = ST_IDLE;
                else if (!phase_reg)
                    phase_next = 1'b1;
                else
                begin
                    we        = 1'b1;
                    wdata     = (halved <= prev_reg) ? prev_reg + FREQ_W'(1) : halved;
                    prev_next = wdata;
                    idx_next  = idx_reg + 1'b1;
                    phase_next = 1'b0;
                end
            end
            ST_FLUSH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next          = 1'b1;
                    od_next.out_byte = low_reg[63:56];
                    od_next.last     = (nout_reg == 4'd7);
                    low_next         = {low_reg[55:0], 8'd0};
                    nout_next        = nout_reg + 1'b1;
                    if (nout_reg == 4'd7)
                    begin
                        low_next   = '0;
                        range_next = '1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            count_reg      <= COUNT_W'(256);
            low_reg        <= '0;
            range_reg      <= '1;
            idx_reg        <= '0;
            nout_reg       <= '0;
            phase_reg      <= 1'b0;
            clear_pend_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            idx_reg        <= idx_next;
            nout_reg       <= nout_next;
            phase_reg      <= phase_next;
            clear_pend_reg <= clear_pend_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mplier_reg    <= mplier_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        prev_reg      <= prev_next;
        total_reg     <= total_next;
        sym_reg       <= sym_next;
        od_reg        <= od_next;
        byte_hold_reg <= byte_hold_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

FILE: design/are_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by a FREQ_W divisor.
// Depends on are_pkg.
module are_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [63:0]               dividend,
    input  logic [are_pkg::FREQ_W-1:0] divisor,
    output are_pkg::div_ctl_t         ctl,
    output logic [63:0]               quotient
);
    import are_pkg::*;

    logic [63:0]       quo_reg, quo_next;
    logic [FREQ_W:0]   rem_reg, rem_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [FREQ_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[FREQ_W-1:0], quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quotient  = quo_reg;
endmodule

FILE: design/are_freq_mem.sv
// Cumulative frequency memory, one write and one registered read port.
// Depends on are_pkg.
module are_freq_mem #(
    parameter int DEPTH = are_pkg::MAX_SYMBOLS_DEF + 1
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [are_pkg::FREQ_W-1:0]   wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [are_pkg::FREQ_W-1:0]   rdata
);
    import are_pkg::*;

    logic [FREQ_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
